[rtl/hm_pkg.sv]
package hm_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [3:0] SYN_MAX = 4'd12;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]       n_res;
    result_t [1:0]    res;
    logic [1:0]       phase;
    logic [7:0]       held;
  } step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } decoded_t;

  function automatic logic [11:0] ham_encode(input logic [7:0] d);
    logic p1, p2, p4, p8;
    p1 = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
    p2 = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
    p4 = d[1] ^ d[2] ^ d[3] ^ d[7];
    p8 = d[4] ^ d[5] ^ d[6] ^ d[7];
    return {d[7], d[6], d[5], d[4], p8, d[3], d[2], d[1], p4, d[0], p2, p1};
  endfunction

  function automatic logic [3:0] ham_syndrome(input logic [11:0] cw);
    logic s1, s2, s4, s8;
    s1 = cw[0] ^ cw[2] ^ cw[4] ^ cw[6] ^ cw[8] ^ cw[10];
    s2 = cw[1] ^ cw[2] ^ cw[5] ^ cw[6] ^ cw[9] ^ cw[10];
    s4 = cw[3] ^ cw[4] ^ cw[5] ^ cw[6] ^ cw[11];
    s8 = cw[7] ^ cw[8] ^ cw[9] ^ cw[10] ^ cw[11];
    return {s8, s4, s2, s1};
  endfunction

  function automatic decoded_t ham_decode(input logic [11:0] cw_in);
    logic [3:0]  s;
    logic [11:0] cw;
    decoded_t    r;
    cw = cw_in;
    s  = ham_syndrome(cw_in);
    if (s > SYN_MAX) begin
      r.data = 8'd0;
      r.err  = 1'b1;
    end else begin
      if (s != 4'd0) begin
        cw[s - 4'd1] = ~cw[s - 4'd1];
      end
      r.data = {cw[11], cw[10], cw[9], cw[8], cw[6], cw[5], cw[4], cw[2]};
      r.err  = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/hamming_12_8_byte_stream_codec.sv]
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_byte[7:0]
// out      output     out_valid / out_stall  out_byte[7:0], out_error, out_last
// cfg      input      cfg_valid / cfg_ready  cfg_data (mode)
//
// Each input transaction is coded in the cycle it is accepted and its results enter a
// two-entry result queue, so an item with one result can be accepted every cycle while
// out_stall is low. The second byte of an encode pair yields two results and waits for
// an empty queue, so encoding throughput is set by the one-byte out channel.
// Synchronous active-low reset clears mode, pair phase and the result queue.
// in_stall depends only on registered state; out_stall only holds the queue head.
module hamming_12_8_byte_stream_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_error,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import hm_pkg::*;

  logic          mode_r, mode_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  result_t [1:0] q_r, q_nxt;
  step_t         step;
  logic [1:0]    need;
  logic          in_acc, pop, cfg_acc;
  logic [1:0]    cnt_pop;
  logic          slot;

  hm_step u_step (
    .mode    (mode_r),
    .phase   (phase_r),
    .held    (held_r),
    .in_byte (in_byte),
    .step    (step)
  );

  assign need      = step.n_res;
  assign in_stall  = (need > (2'd2 - cnt_r));
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_byte  = q_r[0].data;
  assign out_error = q_r[0].err;
  assign out_last  = q_r[0].last;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    q_nxt     = q_r;
    slot      = 1'b0;
    cnt_pop   = cnt_r - {1'b0, pop};
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    cnt_nxt = cnt_pop;
    if (cfg_acc) begin
      mode_nxt  = cfg_data;
      phase_nxt = PH_FIRST;
      held_nxt  = 8'd0;
    end else if (in_acc) begin
      phase_nxt = step.phase;
      held_nxt  = step.held;
      cnt_nxt   = cnt_pop + need;
      for (int i = 0; i < 2; i++) begin
        slot = cnt_pop[0] ^ 1'(i);
        if (2'(i) < need) begin
          q_nxt[slot] = step.res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENCODE;
      phase_r <= PH_FIRST;
      held_r  <= 8'd0;
      cnt_r   <= 2'd0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue overflow");

  a_encode_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode_r == MODE_ENCODE && !$past(cfg_acc)) |-> !out_error)
    else $error("error flag set on an encoded byte");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (phase_r == PH_FIRST && held_r == 8'd0))
    else $error("mode write did not restart the group");

  a_decode_first_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc && mode_r == MODE_DECODE && phase_r == PH_FIRST && !pop)
      |=> (cnt_r == $past(cnt_r)))
    else $error("first byte of a decode group produced a result");

  a_pair_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc && mode_r == MODE_ENCODE && phase_r == PH_SECOND)
      |=> (cnt_r == 2'd2 && !q_r[0].last && q_r[1].last))
    else $error("second byte of an encode pair did not queue two results");
`endif

endmodule

[rtl/hm_step.sv]
module hm_step (
  input  logic          mode,
  input  logic [1:0]    phase,
  input  logic [7:0]    held,
  input  logic [7:0]    in_byte,
  output hm_pkg::step_t step
);
  import hm_pkg::*;

  logic [11:0] cw_enc;
  decoded_t    dec_a;
  decoded_t    dec_b;

  assign cw_enc = ham_encode(in_byte);
  assign dec_a  = ham_decode({held, in_byte[7:4]});
  assign dec_b  = ham_decode({held[3:0], in_byte});

  always_comb begin
    step = '0;
    if (mode == MODE_ENCODE) begin
      if (phase == PH_SECOND) begin
        step.n_res  = 2'd2;
        step.res[0] = '{data: {held[3:0], cw_enc[11:8]}, err: 1'b0, last: 1'b0};
        step.res[1] = '{data: cw_enc[7:0], err: 1'b0, last: 1'b1};
        step.phase  = PH_FIRST;
        step.held   = 8'd0;
      end else begin
        step.n_res  = 2'd1;
        step.res[0] = '{data: cw_enc[11:4], err: 1'b0, last: 1'b1};
        step.phase  = PH_SECOND;
        step.held   = {4'd0, cw_enc[3:0]};
      end
    end else begin
      if (phase == PH_SECOND) begin
        step.n_res  = 2'd1;
        step.res[0] = '{data: dec_a.data, err: dec_a.err, last: 1'b1};
        step.phase  = PH_THIRD;
        step.held   = {4'd0, in_byte[3:0]};
      end else if (phase == PH_THIRD) begin
        step.n_res  = 2'd1;
        step.res[0] = '{data: dec_b.data, err: dec_b.err, last: 1'b1};
        step.phase  = PH_FIRST;
        step.held   = 8'd0;
      end else begin
        step.n_res  = 2'd0;
        step.phase  = PH_SECOND;
        step.held   = in_byte;
      end
    end
  end

endmodule

[dv/hamming_12_8_byte_stream_codec_test.sv]
`timescale 1ns / 100ps

module hamming_12_8_byte_stream_codec_test;
  import hm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 90;
  localparam int PHASE_ITEMS = 88;

  class codec_scoreboard;
    logic       mode = MODE_ENCODE;
    logic [1:0] phase = PH_FIRST;
    logic [7:0] held = 8'd0;
    result_t    expected_bytes[$];
    int         mismatches = 0;
    int         inputs_seen = 0;
    int         results_seen = 0;
    int         uncorrectable = 0;
    int         mode_writes = 0;

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function int data_pos(int k);
      if (k == 0) begin
        return 3;
      end
      return (k < 4) ? k + 4 : k + 5;
    endfunction

    function logic [3:0] syndrome(logic [11:0] cw);
      logic [3:0] s;
      s = 4'd0;
      for (int i = 1; i <= 12; i++) begin
        if (cw[i - 1]) begin
          s = s ^ 4'(i);
        end
      end
      return s;
    endfunction

    function logic [11:0] encode_byte(logic [7:0] d);
      logic [11:0] cw;
      logic [3:0]  par;
      cw = 12'd0;
      for (int k = 0; k < 8; k++) begin
        cw[data_pos(k) - 1] = d[k];
      end
      par = syndrome(cw);
      cw[0] = par[0];
      cw[1] = par[1];
      cw[3] = par[2];
      cw[7] = par[3];
      return cw;
    endfunction

    function void queue_result(logic [7:0] d, logic e, logic l);
      result_t r;
      r.data = d;
      r.err  = e;
      r.last = l;
      expected_bytes.push_back(r);
    endfunction

    function void queue_decoded(logic [11:0] cw);
      logic [3:0]  s;
      logic [11:0] fixed;
      logic [7:0]  d;
      s = syndrome(cw);
      fixed = cw;
      d = 8'd0;
      if (s > SYN_MAX) begin
        uncorrectable++;
        queue_result(8'd0, 1'b1, 1'b1);
      end else begin
        if (s != 4'd0) begin
          fixed[s - 4'd1] = ~fixed[s - 4'd1];
        end
        for (int k = 0; k < 8; k++) begin
          d[k] = fixed[data_pos(k) - 1];
        end
        queue_result(d, 1'b0, 1'b1);
      end
    endfunction

    function void set_mode(logic m);
      mode = m;
      phase = PH_FIRST;
      held = 8'd0;
      mode_writes++;
    endfunction

    function void take_input_byte(logic [7:0] b);
      logic [11:0] cw;
      inputs_seen++;
      if (mode == MODE_ENCODE) begin
        cw = encode_byte(b);
        if (phase == PH_SECOND) begin
          queue_result({held[3:0], cw[11:8]}, 1'b0, 1'b0);
          queue_result(cw[7:0], 1'b0, 1'b1);
          phase = PH_FIRST;
          held = 8'd0;
        end else begin
          queue_result(cw[11:4], 1'b0, 1'b1);
          held = {4'd0, cw[3:0]};
          phase = PH_SECOND;
        end
      end else if (phase == PH_SECOND) begin
        queue_decoded({held, b[7:4]});
        held = {4'd0, b[3:0]};
        phase = PH_THIRD;
      end else if (phase == PH_THIRD) begin
        queue_decoded({held[3:0], b});
        held = 8'd0;
        phase = PH_FIRST;
      end else begin
        held = b;
        phase = PH_SECOND;
      end
    endfunction

    task check_result(logic [7:0] b, logic e, logic l);
      result_t x;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected result byte %02h err %b last %b", b, e, l));
      end else begin
        x = expected_bytes.pop_front();
        if (b !== x.data) begin
          report($sformatf("out_byte %02h, expected %02h", b, x.data));
        end
        if (e !== x.err) begin
          report($sformatf("out_error %b, expected %b", e, x.err));
        end
        if (l !== x.last) begin
          report($sformatf("out_last %b, expected %b", l, x.last));
        end
      end
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction

    task finish_check();
      if (expected_bytes.size() != 0) begin
        report($sformatf("%0d expected results never arrived", expected_bytes.size()));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_error;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  codec_scoreboard sb = new();
  bit hold_req = 1'b0;
  int burst_left = 0;
  int cycle_count = 0;

  hamming_12_8_byte_stream_codec dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_error (out_error),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_byte, out_error, out_last);
    end
  end

  initial begin
    int run_left;
    int style;
    int hold_left;
    out_stall = 1'b0;
    run_left = 0;
    style = 0;
    hold_left = 0;
    @(negedge clk);
    forever begin
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0) begin
          hold_req = 1'b0;
        end
      end else begin
        if (run_left == 0) begin
          style = $urandom_range(0, 9);
          run_left = (style == 9) ? $urandom_range(5, 30) : $urandom_range(10, 60);
        end
        case (style)
          0, 1, 2: begin
            out_stall <= 1'b0;
          end
          3, 4, 5, 6: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          7, 8: begin
            out_stall <= ($urandom_range(0, 1) == 0);
          end
          default: begin
            out_stall <= 1'b1;
          end
        endcase
        run_left--;
      end
      @(negedge clk);
    end
  end

  function int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 65) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  // Called at a falling edge; returns at a falling edge with in_valid still high
  // when no gap follows the transaction.
  task send_byte(logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) begin
        break;
      end
    end
    sb.take_input_byte(b);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task send_group(logic [11:0] cw_a, logic [11:0] cw_b);
    send_byte(cw_a[11:4]);
    send_byte({cw_a[3:0], cw_b[11:8]});
    send_byte(cw_b[7:0]);
  endtask

  // The input must be idle and all results drained before the mode changes.
  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    forever begin
      @(posedge clk);
      if (cfg_ready) begin
        break;
      end
    end
    sb.set_mode(m);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function logic [11:0] corrupt(logic [11:0] cw);
    int r;
    logic [11:0] c;
    r = $urandom_range(0, 9);
    c = cw;
    if (r >= 4 && r <= 8) begin
      c[$urandom_range(0, 11)] ^= 1'b1;
    end
    if (r == 8) begin
      c[$urandom_range(0, 11)] ^= 1'b1;
    end
    if (r == 9) begin
      c = 12'($urandom());
    end
    return c;
  endfunction

  function logic [7:0] random_data();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom());
  endfunction

  initial begin
    int sent;
    logic m;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'd0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Encode from reset; the odd last byte leaves a half pair that the mode write drops.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hA5);
    drain();
    write_mode(MODE_DECODE);

    // Clean words, single errors, and the three uncorrectable syndromes.
    send_group(sb.encode_byte(8'h00), sb.encode_byte(8'hFF));
    send_group(sb.encode_byte(8'h5A) ^ 12'h801, sb.encode_byte(8'h96) ^ 12'h040);
    send_group(12'hFFF, sb.encode_byte(8'h3C) ^ 12'h804);
    send_group(sb.encode_byte(8'hC3) ^ 12'h802, 12'h000);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    for (int p = 0; p < 6; p++) begin
      m = (p < 4) ? logic'(p % 2) : logic'($urandom_range(0, 1));
      write_mode(m);
      sent = 0;
      if (p == 0) begin
        // The receiver holds off while the sender keeps offering back to back.
        hold_req = 1'b1;
        burst_left = 30;
      end
      while (sent < PHASE_ITEMS) begin
        if (m == MODE_ENCODE) begin
          send_byte(random_data());
          sent++;
        end else if ($urandom_range(0, 99) < 15) begin
          send_byte(8'($urandom()));
          sent++;
        end else begin
          send_group(corrupt(sb.encode_byte(random_data())),
                     corrupt(sb.encode_byte(random_data())));
          sent += 3;
        end
      end
      drain();
    end

    repeat (20) @(negedge clk);
    sb.finish_check();
    $display("Sent %0d input bytes across %0d mode writes and checked %0d result bytes.",
             sb.inputs_seen, sb.mode_writes, sb.results_seen);
    $display("Decoding met %0d uncorrectable codewords; %0d mismatches were found.",
             sb.uncorrectable, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
